/* rtl/prm_pkg.sv */
package prm_pkg;

    localparam int ENTRIES    = 16;
    localparam int ADDR_WIDTH = 32;

    localparam int FIELD_ADDR_W  = 32;
    localparam int FIELD_INDEX_W = 4;
    localparam int PRIO_W        = 8;
    localparam int COUNT_W       = 5;

    localparam int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int ACT_W      = (IDX_W + 1 > COUNT_W) ? IDX_W + 1 : COUNT_W;
    localparam int SLOT_W     = (IDX_W > FIELD_INDEX_W) ? IDX_W : FIELD_INDEX_W;
    localparam int ADDR_EXT_W = (ADDR_WIDTH > FIELD_ADDR_W) ? ADDR_WIDTH : FIELD_ADDR_W;

    localparam int IN_DATA_W  = 112;
    localparam int OUT_DATA_W = 16;

    typedef logic [ADDR_WIDTH-1:0] addr_t;
    typedef logic [PRIO_W-1:0]     prio_t;
    typedef logic [IDX_W-1:0]      idx_t;

    typedef enum logic
    {
        OP_WRITE  = 1'b0,
        OP_LOOKUP = 1'b1
    } prm_op_t;

    typedef struct packed
    {
        prm_op_t                  opcode;
        logic [FIELD_INDEX_W-1:0] entry_index;
        addr_t                    region_start;
        addr_t                    region_end;
        prio_t                    region_priority;
        addr_t                    lookup_address;
        logic                     found;
        idx_t                     best_index;
        prio_t                    best_priority;
    } prm_beat_t;

    function automatic addr_t to_addr(input logic [FIELD_ADDR_W-1:0] value);
        logic [ADDR_EXT_W-1:0] wide;
        begin
            wide = ADDR_EXT_W'(value);
            return wide[ADDR_WIDTH-1:0];
        end
    endfunction

    function automatic logic [FIELD_INDEX_W-1:0] to_match_index(input idx_t value);
        logic [SLOT_W-1:0] wide;
        begin
            wide = SLOT_W'(value);
            return wide[FIELD_INDEX_W-1:0];
        end
    endfunction

endpackage

/* rtl/prm_cell.sv */
module prm_cell
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         advance,
    input  prm_pkg::idx_t                cell_index,
    input  logic [prm_pkg::COUNT_W-1:0]  entry_count,
    input  logic                         valid_in,
    input  prm_pkg::prm_beat_t           beat_in,
    output logic                         valid_out,
    output prm_pkg::prm_beat_t           beat_out
);

    prm_pkg::addr_t     start_reg;
    prm_pkg::addr_t     end_reg;
    prm_pkg::prio_t     prio_reg;
    logic               valid_reg;
    prm_pkg::prm_beat_t beat_reg;
    prm_pkg::prm_beat_t beat_next;

    logic is_active;
    logic slot_match;
    logic do_write;
    logic in_region;
    logic take;

    assign is_active  = prm_pkg::ACT_W'(cell_index) < prm_pkg::ACT_W'(entry_count);
    assign slot_match = prm_pkg::SLOT_W'(beat_in.entry_index) == prm_pkg::SLOT_W'(cell_index);
    assign do_write   = advance && valid_in && (beat_in.opcode == prm_pkg::OP_WRITE) && slot_match;
    assign in_region  = (beat_in.lookup_address >= start_reg) &&
                        (beat_in.lookup_address <= end_reg);
    assign take       = (beat_in.opcode == prm_pkg::OP_LOOKUP) && is_active && in_region &&
                        (!beat_in.found || (prio_reg < beat_in.best_priority));

    always_comb
    begin
        beat_next = beat_in;
        if (take)
        begin
            beat_next.found         = 1'b1;
            beat_next.best_index    = cell_index;
            beat_next.best_priority = prio_reg;
        end
    end

    // table entry held by this cell
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            start_reg <= beat_in.region_start;
            end_reg   <= beat_in.region_end;
            prio_reg  <= beat_in.region_priority;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            beat_reg <= beat_next;
        end
    end

    assign valid_out = valid_reg;
    assign beat_out  = beat_reg;

endmodule

/* rtl/priority_region_match.sv */
// a result passes through the register of every entry cell, in index order, and then the output register
// throughput: one beat per cycle while not stalled; every beat walks the chain of entry cells, one cell a cycle
// the chain stalls as a whole while the output register holds an untaken result
// reset: asynchronous, active low; clears entry_count and all valid flags
// table entries are not cleared by reset and read as undefined until written
module priority_region_match
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [prm_pkg::COUNT_W-1:0]      cfg_wdata,    // entry_count
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [prm_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // entry_index, region_start,
                                                            // region_end, region_priority,
                                                            // lookup_address, zero pad
    input  logic                             s_axis_tuser,  // opcode
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [prm_pkg::OUT_DATA_W-1:0]   m_axis_tdata   // hit, matched_index,
                                                            // matched_priority, zero pad
);

    logic [prm_pkg::COUNT_W-1:0] entry_count_reg;
    logic                        out_valid_reg;
    logic [prm_pkg::OUT_DATA_W-1:0] out_data_reg;
    logic [prm_pkg::OUT_DATA_W-1:0] out_data_next;

    logic               advance;
    prm_pkg::prm_beat_t in_beat;

    logic               chain_valid [prm_pkg::ENTRIES+1];
    prm_pkg::prm_beat_t chain_beat  [prm_pkg::ENTRIES+1];

    prm_pkg::prm_beat_t last_beat;
    logic               hit;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = advance;

    always_comb
    begin
        in_beat                 = '0;
        in_beat.opcode          = prm_pkg::prm_op_t'(s_axis_tuser);
        in_beat.entry_index     = s_axis_tdata[3:0];
        in_beat.region_start    = prm_pkg::to_addr(s_axis_tdata[35:4]);
        in_beat.region_end      = prm_pkg::to_addr(s_axis_tdata[67:36]);
        in_beat.region_priority = s_axis_tdata[75:68];
        in_beat.lookup_address  = prm_pkg::to_addr(s_axis_tdata[107:76]);
        in_beat.found           = 1'b0;
        in_beat.best_index      = '0;
        in_beat.best_priority   = '0;
    end

    assign chain_valid[0] = s_axis_tvalid;
    assign chain_beat[0]  = in_beat;

    genvar gi;
    generate
        for (gi = 0; gi < prm_pkg::ENTRIES; gi++)
        begin : g_cell
            prm_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .advance     (advance),
                .cell_index  (prm_pkg::IDX_W'(gi)),
                .entry_count (entry_count_reg),
                .valid_in    (chain_valid[gi]),
                .beat_in     (chain_beat[gi]),
                .valid_out   (chain_valid[gi+1]),
                .beat_out    (chain_beat[gi+1])
            );
        end
    endgenerate

    assign last_beat = chain_beat[prm_pkg::ENTRIES];
    assign hit       = last_beat.found && (last_beat.opcode == prm_pkg::OP_LOOKUP);

    always_comb
    begin
        out_data_next       = '0;
        out_data_next[0]    = hit;
        if (hit)
        begin
            out_data_next[4:1]  = prm_pkg::to_match_index(last_beat.best_index);
            out_data_next[12:5] = last_beat.best_priority;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                entry_count_reg <= cfg_wdata;
            end
            if (advance)
            begin
                out_valid_reg <= chain_valid[prm_pkg::ENTRIES];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import prm_pkg::*;

    localparam int ITEMS  = 1950;
    localparam int PHASES = 12;

    // s_axis_tdata, lowest bit up: entry_index, region_start, region_end,
    // region_priority, lookup_address, zero pad
    typedef struct packed
    {
        logic [3:0]            zero_pad;
        logic [31:0]           lookup_address;
        logic [PRIO_W-1:0]     region_priority;
        logic [31:0]           region_end;
        logic [31:0]           region_start;
        logic [3:0]            entry_index;
    } region_beat_t;

    // m_axis_tdata, lowest bit up: hit, matched_index, matched_priority, zero pad
    typedef struct packed
    {
        logic [2:0]            zero_pad;
        logic [PRIO_W-1:0]     matched_priority;
        logic [3:0]            matched_index;
        logic                  hit;
    } match_result_t;

    class match_scoreboard;
        logic [31:0]       lo_bound [ENTRIES];
        logic [31:0]       hi_bound [ENTRIES];
        logic [PRIO_W-1:0] rank [ENTRIES];
        int unsigned       active_count = 0;
        match_result_t     expected_matches [$];
        int unsigned       mismatches = 0;
        int unsigned       writes = 0;
        int unsigned       lookups = 0;
        int unsigned       hits = 0;

        function void set_count(int unsigned value);
            active_count = value;
        endfunction

        function match_result_t predict_match(logic [31:0] addr);
            match_result_t res;
            int unsigned   limit;
            res = '0;
            limit = (active_count > ENTRIES) ? ENTRIES : active_count;
            for (int i = 0; i < limit; i++)
            begin
                if (addr >= lo_bound[i] && addr <= hi_bound[i] &&
                    (!res.hit || rank[i] < res.matched_priority))
                begin
                    res.hit = 1'b1;
                    res.matched_index = 4'(i);
                    res.matched_priority = rank[i];
                end
            end
            return res;
        endfunction

        function void note_beat(prm_op_t op, region_beat_t beat);
            match_result_t res;
            res = '0;
            if (op == OP_WRITE)
            begin
                writes++;
                if (beat.entry_index < ENTRIES)
                begin
                    lo_bound[beat.entry_index] = beat.region_start;
                    hi_bound[beat.entry_index] = beat.region_end;
                    rank[beat.entry_index] = beat.region_priority;
                end
            end
            else
            begin
                lookups++;
                res = predict_match(beat.lookup_address);
                if (res.hit)
                    hits++;
            end
            expected_matches.push_back(res);
        endfunction

        function void check_result(match_result_t got);
            match_result_t want;
            if (expected_matches.size() == 0)
            begin
                mismatches++;
                $display("%0t: result %h with none expected", $time, got);
                return;
            end
            want = expected_matches.pop_front();
            if (got.hit !== want.hit)
            begin
                mismatches++;
                $display("%0t: hit expected %0d actual %0d", $time, want.hit, got.hit);
            end
            if (got.matched_index !== want.matched_index)
            begin
                mismatches++;
                $display("%0t: matched_index expected %0d actual %0d", $time,
                         want.matched_index, got.matched_index);
            end
            if (got.matched_priority !== want.matched_priority)
            begin
                mismatches++;
                $display("%0t: matched_priority expected %0d actual %0d", $time,
                         want.matched_priority, got.matched_priority);
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [COUNT_W-1:0]     cfg_wdata = '0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;

    match_scoreboard sb;
    logic            calm = 1'b0;
    int unsigned     stall_left = 0;
    int unsigned     count_settings = 0;

    priority_region_match uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                sb.note_beat(prm_op_t'(s_axis_tuser), s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready)
                sb.check_result(m_axis_tdata);
        end
    end

    task automatic send_beat(input prm_op_t op, input region_beat_t beat);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= beat;
        do @(posedge clk); while (!s_axis_tready);
    endtask

    task automatic write_slot(input logic [3:0] slot, input logic [31:0] lo,
                              input logic [31:0] hi, input logic [PRIO_W-1:0] pr);
        region_beat_t beat;
        beat = '0;
        beat.entry_index = slot;
        beat.region_start = lo;
        beat.region_end = hi;
        beat.region_priority = pr;
        beat.lookup_address = $urandom;
        send_beat(OP_WRITE, beat);
    endtask

    task automatic lookup(input logic [31:0] addr);
        region_beat_t beat;
        beat = '0;
        beat.entry_index = 4'($urandom);
        beat.region_start = $urandom;
        beat.region_end = $urandom;
        beat.region_priority = 8'($urandom);
        beat.lookup_address = addr;
        send_beat(OP_LOOKUP, beat);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.expected_matches.size() != 0)
            @(posedge clk);
        repeat (ENTRIES + 4) @(posedge clk);
    endtask

    task automatic set_count(input int unsigned value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= COUNT_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_count(value);
        count_settings++;
    endtask

    task automatic random_write();
        logic [3:0]        slot;
        logic [31:0]       lo;
        logic [31:0]       hi;
        logic [31:0]       span;
        logic [31:0]       other;
        logic [PRIO_W-1:0] pr;
        int unsigned       kind;
        int unsigned       peer;
        slot = 4'($urandom);
        peer = $urandom_range(0, ENTRIES - 1);
        kind = $urandom_range(0, 99);
        lo = $urandom;
        span = $urandom >> $urandom_range(0, 31);
        if (kind < 55)
            hi = (lo > ~span) ? '1 : lo + span;
        else if (kind < 65)
        begin
            lo = $urandom_range(0, 15);
            hi = span;
        end
        else if (kind < 73)
        begin
            hi = 32'hFFFF_FFFF - $urandom_range(0, 15);
            lo = hi - span;
        end
        else if (kind < 83)
        begin
            // inverted region, never matches unless both draws are zero and it wraps to the full range
            other = $urandom;
            hi = (lo < other) ? lo : other;
            lo = (lo < other) ? other : lo;
            if (lo == hi)
                hi = lo - 1;
        end
        else if (kind < 88)
        begin
            lo = '0;
            hi = '1;
        end
        else
        begin
            lo = sb.lo_bound[peer];
            hi = sb.hi_bound[peer];
        end
        case ($urandom_range(0, 3))
            0: pr = sb.rank[peer];
            1: pr = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: pr = 8'($urandom);
        endcase
        write_slot(slot, lo, hi, pr);
    endtask

    task automatic random_lookup();
        int unsigned slot;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [31:0] addr;
        slot = $urandom_range(0, ENTRIES - 1);
        lo = sb.lo_bound[slot];
        hi = sb.hi_bound[slot];
        case ($urandom_range(0, 9))
            0: addr = lo;
            1: addr = hi;
            2: addr = lo - 1;
            3: addr = hi + 1;
            4, 5, 6: addr = lo + ($urandom & ((hi - lo) >> $urandom_range(0, 31)));
            7: addr = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
            default: addr = $urandom;
        endcase
        lookup(addr);
    endtask

    initial
    begin
        int unsigned next_count;
        sb = new;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing active after reset
        lookup(32'h0);
        lookup(32'hFFFF_FFFF);

        write_slot(4'd0, 32'h0, 32'hFFFF_FFFF, 8'd255);
        write_slot(4'd1, 32'h1000, 32'h1FFF, 8'd10);
        write_slot(4'd2, 32'h1800, 32'h27FF, 8'd10);
        write_slot(4'd3, 32'h1800, 32'h18FF, 8'd0);
        write_slot(4'd4, 32'h5000, 32'h4000, 8'd0);
        write_slot(4'd5, 32'hFFFF_FF00, 32'hFFFF_FFFF, 8'd5);
        write_slot(4'd6, 32'h0, 32'h0, 8'd7);
        for (int i = 7; i < ENTRIES; i++)
            write_slot(4'(i), 32'(i << 20), 32'(i << 20) + 32'hFFFF, 8'(i * 17));

        set_count(ENTRIES);
        lookup(32'h0);
        lookup(32'h1000);
        lookup(32'h1800);
        lookup(32'h1FFF);
        lookup(32'h2000);
        lookup(32'h4800);
        lookup(32'hFFFF_FFFF);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0: next_count = ENTRIES;
                1: next_count = 1;
                2: next_count = ENTRIES - 1;
                3: next_count = 0;
                default: next_count = $urandom_range(0, ENTRIES);
            endcase
            set_count(next_count);
            calm = (phase % 4 == 1);
            repeat (ITEMS / PHASES)
            begin
                if ($urandom_range(0, 9) == 0)
                    random_write();
                else
                    random_lookup();
            end
        end
        calm = 1'b0;
        drain();

        $display("covered %0d table writes and %0d lookups (%0d hits)", sb.writes,
                 sb.lookups, sb.hits);
        $display("across %0d entry_count settings, with stalls on both streams",
                 count_settings);
        if (sb.mismatches == 0)
            $display("priority_region_match test passed");
        else
            $display("priority_region_match test failed");
        $finish;
    end

    initial
    begin
        #(20_000_000);
        $display("priority_region_match test failed");
        $finish;
    end

endmodule
